[rtl/core/bfs_pkg.sv]
// Shared types, constants and helpers for the bitmap find-first-and-set block.
package bfs_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 6;
  localparam int STS_W     = 2;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STS_W-1:0] ST_NONE  = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FIND  = 1'b1;

  localparam logic [CNT_W-1:0] WORD_COUNT_RST = 6'd32;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic post_range;
    logic wr_back;
    logic find_step;
  } bfs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_err;
    logic find_hit;
    logic find_none;
  } bfs_sts_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/bitmap_find_first_and_set.sv]
// Top level of the bitmap find-first-and-set block.
// A bitmap of MAX_WORDS 32-bit words in one single-port-read memory. After reset the
// block is busy while a clearing pass zeroes the memory word by word; cfg writes are
// taken throughout. An item is taken when start is high and busy low.
// A bit write runs a memory read, then a write-back, and its result beat
// appears in the cycle after; an out-of-range write answers in the cycle after accept.
// A find reads one word per cycle from the memory port and walks at most word_count
// words (word_count capped at MAX_WORDS): after the accept it reads each word in
// turn and checks the last word read, then shows its result beat.
// Each result beat is shown for one cycle on out_strobe and cannot be held off;
// the next item may be started in the cycle the beat is shown.
module bitmap_find_first_and_set #(
  parameter int MAX_WORDS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfs_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [bfs_pkg::IDX_W-1:0]   in_bit_index,
  input  logic                        in_bit_value,
  output logic                        out_strobe,
  output logic [bfs_pkg::STS_W-1:0]   out_status,
  output logic [bfs_pkg::IDX_W-1:0]   out_position
);

  bfs_pkg::bfs_cmd_t cmd;
  bfs_pkg::bfs_sts_t sts;

  bfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  bfs_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mode      (in_mode),
    .in_bit_index (in_bit_index),
    .in_bit_value (in_bit_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_position (out_position)
  );

endmodule

[rtl/core/bfs_ctrl.sv]
// Controller state machine: clearing pass, bit write and find sequencing.
module bfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_mode,
  input  bfs_pkg::bfs_sts_t sts,
  output bfs_pkg::bfs_cmd_t cmd,
  output logic              busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_FIND  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_mode == bfs_pkg::MODE_FIND) begin
            state_nxt = S_FIND;
          end else if (sts.range_err) begin
            cmd.post_range = 1'b1;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_back = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.find_hit || sts.find_none) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/core/bfs_datapath.sv]
// Datapath: bitmap memory, word-count register, find walk and result registers.
module bfs_datapath #(
  parameter int MAX_WORDS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfs_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                        in_mode,
  input  logic [bfs_pkg::IDX_W-1:0]   in_bit_index,
  input  logic                        in_bit_value,
  input  bfs_pkg::bfs_cmd_t           cmd,
  output bfs_pkg::bfs_sts_t           sts,
  output logic                        out_strobe,
  output logic [bfs_pkg::STS_W-1:0]   out_status,
  output logic [bfs_pkg::IDX_W-1:0]   out_position
);

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int XW  = (AW > bfs_pkg::CNT_W) ? AW : bfs_pkg::CNT_W;
  localparam int CAP = (MAX_WORDS < 63) ? MAX_WORDS : 63;
  localparam logic [bfs_pkg::CNT_W-1:0] CAP_N    = bfs_pkg::CNT_W'(CAP);
  localparam logic [AW-1:0]             LAST_ADR = AW'(MAX_WORDS - 1);

  logic [bfs_pkg::WORD_BITS-1:0] mem [MAX_WORDS];
  logic [bfs_pkg::WORD_BITS-1:0] rd_data_r;

  logic [bfs_pkg::CNT_W-1:0] word_count_r;
  logic [bfs_pkg::CNT_W-1:0] n_words;
  logic [AW-1:0]             clr_cnt_r;
  logic [bfs_pkg::CNT_W-1:0] ic_r, ic_nxt;
  logic [bfs_pkg::CNT_W-1:0] ec_r, ec_nxt;
  logic                      ev_r, ev_nxt;
  logic [bfs_pkg::IDX_W-1:0] idx_r;
  logic                      val_r;

  logic                      strobe_r, strobe_nxt;
  logic [bfs_pkg::STS_W-1:0] status_r, status_nxt;
  logic [bfs_pkg::IDX_W-1:0] pos_r, pos_nxt;

  logic                          rd_en, mem_we;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [bfs_pkg::WORD_BITS-1:0] wr_data, wb_word, target;
  logic [XW-1:0]                 in_word_x, idx_word_x, ic_x;
  logic                          issue;

  assign n_words = (word_count_r > CAP_N) ? CAP_N : word_count_r;

  assign in_word_x  = XW'(in_bit_index[bfs_pkg::IDX_W-1:bfs_pkg::BIT_W]);
  assign idx_word_x = XW'(idx_r[bfs_pkg::IDX_W-1:bfs_pkg::BIT_W]);
  assign ic_x       = XW'(ic_r);

  assign sts.clr_last  = (clr_cnt_r == LAST_ADR);
  assign sts.range_err = ({1'b0, in_bit_index[bfs_pkg::IDX_W-1:bfs_pkg::BIT_W]} >= n_words);

  assign issue  = cmd.find_step && (ic_r < n_words);
  assign target = val_r ? rd_data_r : ~rd_data_r;

  assign sts.find_hit  = ev_r && (target != '0);
  assign sts.find_none = !sts.find_hit &&
                         (ev_r ? (({1'b0, ec_r} + 7'd1) >= {1'b0, n_words})
                               : (ic_r >= n_words));

  always_comb begin
    wb_word = rd_data_r;
    wb_word[idx_r[bfs_pkg::BIT_W-1:0]] = val_r;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_word_x[AW-1:0];
    mem_we  = 1'b0;
    wr_addr = idx_word_x[AW-1:0];
    wr_data = wb_word;
    if (cmd.clr_step) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.wr_back) begin
      mem_we = 1'b1;
    end
    if (cmd.load && (in_mode == bfs_pkg::MODE_WRITE)) begin
      rd_en = 1'b1;
    end else if (issue) begin
      rd_en   = 1'b1;
      rd_addr = ic_x[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    ic_nxt = ic_r;
    ec_nxt = ec_r;
    ev_nxt = ev_r;
    if (cmd.load) begin
      ic_nxt = '0;
      ev_nxt = 1'b0;
    end else if (cmd.find_step) begin
      ev_nxt = issue;
      ec_nxt = ic_r;
      if (issue) begin
        ic_nxt = ic_r + 1'b1;
      end
    end
  end

  always_comb begin
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    if (cmd.post_range) begin
      strobe_nxt = 1'b1;
      status_nxt = bfs_pkg::ST_RANGE;
      pos_nxt    = '0;
    end else if (cmd.wr_back) begin
      strobe_nxt = 1'b1;
      status_nxt = bfs_pkg::ST_OK;
      pos_nxt    = '0;
    end else if (cmd.find_step && sts.find_hit) begin
      strobe_nxt = 1'b1;
      status_nxt = bfs_pkg::ST_OK;
      pos_nxt    = {ec_r[bfs_pkg::BIT_W-1:0], bfs_pkg::lowest_set(target)};
    end else if (cmd.find_step && sts.find_none) begin
      strobe_nxt = 1'b1;
      status_nxt = bfs_pkg::ST_NONE;
      pos_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= bfs_pkg::WORD_COUNT_RST;
      clr_cnt_r    <= '0;
      ic_r         <= '0;
      ev_r         <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        word_count_r <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      ic_r     <= ic_nxt;
      ev_r     <= ev_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ec_r     <= ec_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    if (cmd.load) begin
      idx_r <= in_bit_index;
      val_r <= in_bit_value;
    end
  end

  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_position = pos_r;

endmodule

[rtl/core/bfs_checker.sv]
// Port-level checker for the bitmap find-first-and-set block, with its bind.
module bfs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [bfs_pkg::STS_W-1:0]   out_status,
  input logic [bfs_pkg::IDX_W-1:0]   out_position
);

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy && !out_strobe)
    else $error("block not busy or strobing after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted item neither in progress nor answered");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while busy");

  a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != bfs_pkg::ST_OK)) |-> (out_position == '0))
    else $error("failed result carries a non-zero position");

endmodule

bind bitmap_find_first_and_set bfs_checker u_bfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_status   (out_status),
  .out_position (out_position)
);

[bench/tb_bitmap_find_first_and_set.sv]
// Self-checking testbench for bitmap_find_first_and_set: bit writes and first-match finds.
module tb_bitmap_find_first_and_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WORDS   = 32;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic                      mode;
    logic [bfs_pkg::IDX_W-1:0] bit_index;
    logic                      bit_value;
  } bit_op_t;

  typedef struct packed {
    logic [bfs_pkg::STS_W-1:0] status;
    logic [bfs_pkg::IDX_W-1:0] position;
  } bit_answer_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      cfg_we       = 1'b0;
  logic [bfs_pkg::CNT_W-1:0] cfg_wdata    = '0;
  logic                      start        = 1'b0;
  logic                      busy;
  logic                      in_mode      = bfs_pkg::MODE_WRITE;
  logic [bfs_pkg::IDX_W-1:0] in_bit_index = '0;
  logic                      in_bit_value = 1'b0;
  logic                      out_strobe;
  logic [bfs_pkg::STS_W-1:0] out_status;
  logic [bfs_pkg::IDX_W-1:0] out_position;

  bit_op_t     pending_ops[$];
  bit_answer_t awaited_answers[$];

  logic [bfs_pkg::WORD_BITS-1:0] bitmap_mirror [MAX_WORDS] = '{default: '0};
  logic [bfs_pkg::CNT_W-1:0]     mirror_words = bfs_pkg::WORD_COUNT_RST;

  int  stim_words   = int'(bfs_pkg::WORD_COUNT_RST);
  int  idle_pct     = 0;
  bit  beat_taken   = 1'b0;
  int  cycle_count  = 0;
  int  errors       = 0;
  int  beats_in     = 0;
  int  answers_seen = 0;
  int  found_seen   = 0;
  int  range_seen   = 0;
  int  none_seen    = 0;
  int  cfg_writes   = 0;

  bitmap_find_first_and_set #(
    .MAX_WORDS(MAX_WORDS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_bit_index(in_bit_index),
    .in_bit_value(in_bit_value),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_position(out_position)
  );

  always #6 clk = ~clk;

  function automatic bit_answer_t apply_bit_op(input logic mode,
                                               input logic [bfs_pkg::IDX_W-1:0] idx,
                                               input logic val);
    bit_answer_t                   ans;
    int                            span;
    logic [bfs_pkg::WORD_BITS-1:0] skip_word;
    logic                          hit;
    ans.status   = bfs_pkg::ST_OK;
    ans.position = '0;
    hit          = 1'b0;
    span         = (mirror_words > MAX_WORDS) ? MAX_WORDS : int'(mirror_words);
    skip_word    = val ? '0 : '1;
    if (mode == bfs_pkg::MODE_WRITE) begin
      if (int'(idx) >= span * bfs_pkg::WORD_BITS) begin
        ans.status = bfs_pkg::ST_RANGE;
      end else begin
        bitmap_mirror[idx[bfs_pkg::IDX_W-1:bfs_pkg::BIT_W]][idx[bfs_pkg::BIT_W-1:0]] = val;
      end
    end else begin
      for (int w = 0; w < span && !hit; w++) begin
        if (bitmap_mirror[w] != skip_word) begin
          for (int b = 0; b < bfs_pkg::WORD_BITS && !hit; b++) begin
            if (bitmap_mirror[w][b] == val) begin
              hit          = 1'b1;
              ans.position = bfs_pkg::IDX_W'(w * bfs_pkg::WORD_BITS + b);
            end
          end
        end
      end
      if (!hit) begin
        ans.status = bfs_pkg::ST_NONE;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin : observe
    bit_answer_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bitmap_find_first_and_set failed");
      $finish;
    end else begin
      if (rst_n && out_strobe) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got status %0d position %0d",
                   $time, out_status, out_position);
          errors++;
        end else begin
          want = awaited_answers.pop_front();
          answers_seen++;
          case (want.status)
            bfs_pkg::ST_OK:    found_seen++;
            bfs_pkg::ST_RANGE: range_seen++;
            default:           none_seen++;
          endcase
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            errors++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position expected %0d, got %0d", $time, want.position,
                     out_position);
            errors++;
          end
        end
      end
      if (rst_n && cfg_we) begin
        mirror_words = cfg_wdata;
      end
      beat_taken = rst_n && start && !busy;
      if (beat_taken) begin
        awaited_answers.push_back(apply_bit_op(in_mode, in_bit_index, in_bit_value));
        beats_in++;
      end
    end
  end

  always @(negedge clk) begin : drive
    bit_op_t op;
    if (!start || beat_taken) begin
      if (rst_n && pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = pending_ops.pop_front();
        start        <= 1'b1;
        in_mode      <= op.mode;
        in_bit_index <= op.bit_index;
        in_bit_value <= op.bit_value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_op(input logic mode, input logic [bfs_pkg::IDX_W-1:0] idx,
                          input logic val);
    bit_op_t op;
    op.mode      = mode;
    op.bit_index = idx;
    op.bit_value = val;
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || awaited_answers.size() != 0 || start) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_word_count(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= bfs_pkg::CNT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    stim_words = value;
    cfg_writes++;
  endtask

  task automatic queue_random(input int count);
    int   made;
    int   span;
    int   pick;
    int   w;
    logic v;
    made = 0;
    span = ((stim_words > MAX_WORDS) ? MAX_WORDS : stim_words) * bfs_pkg::WORD_BITS;
    while (made < count) begin
      pick = $urandom_range(99);
      v    = 1'($urandom_range(1));
      if (pick < 12 && span != 0) begin
        w = $urandom_range(span / bfs_pkg::WORD_BITS - 1);
        for (int b = 0; b < bfs_pkg::WORD_BITS; b++) begin
          queue_op(bfs_pkg::MODE_WRITE, bfs_pkg::IDX_W'(w * bfs_pkg::WORD_BITS + b), v);
        end
        queue_op(bfs_pkg::MODE_FIND, bfs_pkg::IDX_W'($urandom), !v);
        queue_op(bfs_pkg::MODE_FIND, bfs_pkg::IDX_W'($urandom), v);
        made += bfs_pkg::WORD_BITS + 2;
      end else if (pick < 55 && span != 0) begin
        queue_op(bfs_pkg::MODE_WRITE, bfs_pkg::IDX_W'($urandom_range(span - 1)),
                 $urandom_range(99) < 65);
        made++;
      end else if (pick < 65) begin
        queue_op(bfs_pkg::MODE_WRITE, bfs_pkg::IDX_W'($urandom), v);
        made++;
      end else begin
        queue_op(bfs_pkg::MODE_FIND, bfs_pkg::IDX_W'($urandom), v);
        made++;
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n    <= 1'b1;
    idle_pct  = 7;

    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '1, 1'b0);
    queue_op(bfs_pkg::MODE_WRITE, '0, 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b0);
    queue_op(bfs_pkg::MODE_WRITE, '1, 1'b1);
    queue_op(bfs_pkg::MODE_WRITE, '0, 1'b0);
    queue_op(bfs_pkg::MODE_FIND, '1, 1'b1);
    queue_op(bfs_pkg::MODE_WRITE, '1, 1'b0);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);

    set_word_count(1);
    queue_op(bfs_pkg::MODE_WRITE, bfs_pkg::IDX_W'(32), 1'b1);
    queue_op(bfs_pkg::MODE_WRITE, bfs_pkg::IDX_W'(31), 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);
    queue_op(bfs_pkg::MODE_WRITE, '1, 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b0);

    set_word_count(0);
    queue_op(bfs_pkg::MODE_WRITE, '0, 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b0);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);

    set_word_count(63);
    queue_op(bfs_pkg::MODE_WRITE, '1, 1'b1);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);
    queue_op(bfs_pkg::MODE_WRITE, bfs_pkg::IDX_W'(31), 1'b0);
    queue_op(bfs_pkg::MODE_FIND, '0, 1'b1);
    queue_op(bfs_pkg::MODE_WRITE, '1, 1'b0);

    set_word_count(32);
    queue_random(300);
    set_word_count(1);
    queue_random(100);
    set_word_count(20);
    queue_random(100);

    drain();
    idle_pct = 80;
    set_word_count(63);
    queue_random(200);
    set_word_count(0);
    queue_random(60);
    set_word_count($urandom_range(31, 2));
    queue_random(240);

    drain();
    idle_pct = 0;
    set_word_count(32);
    queue_random(250);
    set_word_count($urandom_range(62, 33));
    queue_random(100);
    set_word_count($urandom_range(32, 1));
    queue_random(150);

    drain();
    repeat (40) @(negedge clk);
    $display("Run covered %0d beats over %0d word_count settings with sender gaps of 7, 80, 0%%.",
             beats_in, cfg_writes);
    $display("Results checked: %0d (%0d ok, %0d out of range, %0d none found), %0d errors.",
             answers_seen, found_seen, range_seen, none_seen, errors);
    if (errors == 0) begin
      $display("tb_bitmap_find_first_and_set passed");
    end else begin
      $display("tb_bitmap_find_first_and_set failed");
    end
    $finish;
  end

endmodule

[bitmap_find_first_and_set.f]
rtl/core/bfs_pkg.sv
rtl/core/bfs_ctrl.sv
rtl/core/bfs_datapath.sv
rtl/core/bitmap_find_first_and_set.sv
rtl/core/bfs_checker.sv
bench/tb_bitmap_find_first_and_set.sv
